[rtl/rpn_sensor_scaling_evaluator_core_macros.svh]
// assertion helpers for the checker file
`ifndef RPN_SENSOR_SCALING_EVALUATOR_CORE_MACROS_SVH
`define RPN_SENSOR_SCALING_EVALUATOR_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define RPN_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("rpn checker: implication failed");

// next-cycle implication, disabled in reset
`define RPN_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("rpn checker: next-cycle implication failed");

`endif

[rtl/rpn_sse_pkg.sv]
`timescale 1ns / 1ps

package rpn_sse_pkg;

    localparam int STACK_DEPTH = 10;
    localparam int FRAC_BITS   = 24;

    localparam int SP_W    = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DIV_W   = 64 + FRAC_BITS;
    localparam int DCNT_W  = $clog2(DIV_W + 1);
    localparam int FCNT_W  = 4;
    localparam int MAX_FRAC_DIGITS = 9;

    localparam logic [63:0] Q_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_MINMAG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] M_LIMIT  = 64'd100000000000000000;
    localparam logic [63:0] M_SAT    = 64'd1000000000000000000;

    // sticky error bits
    localparam logic [4:0] E_UNDER = 5'b00001;
    localparam logic [4:0] E_OVER  = 5'b00010;
    localparam logic [4:0] E_DIV0  = 5'b00100;
    localparam logic [4:0] E_SAT   = 5'b01000;
    localparam logic [4:0] E_LIT   = 5'b10000;

    // character codes
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_XU    = 8'h58;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_SHL, OP_SHR
    } op_t;

    typedef enum logic [1:0] {
        PEND_NONE, PEND_LT, PEND_GT
    } pend_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_PRE, S_CHAR, S_FIN, S_LIT, S_DIV, S_LIT_DONE,
        S_OP_RD, S_OP_EXEC, S_MUL, S_MUL_DONE, S_DIV_DONE, S_OUT_RD, S_OUT
    } state_t;

    typedef struct packed {
        logic stop;
        logic digit;
        logic dot;
        logic on;
    } lit_flags_t;

    typedef struct packed {
        logic        sat;
        logic [63:0] val;
    } fin_t;

    function automatic logic [63:0] q_mag(logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // clamp a magnitude to the signed range and apply the sign
    function automatic fin_t q_finish(logic [63:0] m, logic neg, logic over);
        logic [63:0] limit;
        fin_t        r;
        limit = neg ? Q_MINMAG : Q_MAX;
        r.sat = 1'b0;
        r.val = m;
        if (over || (m > limit))
        begin
            r.sat = 1'b1;
            r.val = limit;
        end
        if (neg)
        begin
            r.val = 64'd0 - r.val;
        end
        return r;
    endfunction

    // integer part wrapped to 32 bits
    function automatic logic [31:0] q_to_u32(logic [63:0] v);
        logic [63:0] ip;
        ip = q_mag(v) >> FRAC_BITS;
        if (v[63])
        begin
            ip = 64'd0 - ip;
        end
        return ip[31:0];
    endfunction

    function automatic fin_t q_from_u32(logic [31:0] r);
        return q_finish(64'(r) << FRAC_BITS, 1'b0, 1'b0);
    endfunction

    function automatic logic [63:0] pow_ten(logic [FCNT_W-1:0] k);
        logic [63:0] p;
        case (k)
            4'd0:    p = 64'd1;
            4'd1:    p = 64'd10;
            4'd2:    p = 64'd100;
            4'd3:    p = 64'd1000;
            4'd4:    p = 64'd10000;
            4'd5:    p = 64'd100000;
            4'd6:    p = 64'd1000000;
            4'd7:    p = 64'd10000000;
            4'd8:    p = 64'd100000000;
            4'd9:    p = 64'd1000000000;
            default: p = 64'd1;
        endcase
        return p;
    endfunction

endpackage

[rtl/rpn_in_if.sv]
`timescale 1ns / 1ps

interface rpn_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  expr_char;
    logic [31:0] sample_value;
    logic        last_char;

    modport source (output valid, expr_char, sample_value, last_char, input ready);
    modport sink (input valid, expr_char, sample_value, last_char, output ready);
endinterface

[rtl/rpn_out_if.sv]
`timescale 1ns / 1ps

interface rpn_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] scaled_result;
    logic [4:0]         error_flags;
    logic [3:0]         final_depth;

    modport source (output valid, scaled_result, error_flags, final_depth, input ready);
    modport sink (input valid, scaled_result, error_flags, final_depth, output ready);
endinterface

[rtl/rpn_sensor_scaling_evaluator_core.sv]
`timescale 1ns / 1ps

// channel   dir  payload                                      accepted when
// in_ch     in   expr_char[8] sample_value[32] last_char[1]   valid && ready
// out_ch    out  scaled_result[64] error_flags[5] depth[4]    valid && ready
//
// a plain character passes the decode, pre, char and fin states; an add, sub or
// bit op adds a stack read and an execute. multiply runs four 32x32 partial
// products on one multiplier. divide, remainder and the end of a literal with
// digits share one restoring divider that retires one quotient bit a cycle.
// the last character adds a stack read and the result load; a full output
// register stalls only that load. reset clears control state, not the stack

module rpn_sensor_scaling_evaluator_core
    import rpn_sse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rpn_in_if.sink     in_ch,
    rpn_out_if.source  out_ch
);

    state_t            state_reg, state_next;
    logic [7:0]        char_reg;
    logic [31:0]       sample_reg;
    logic              last_reg;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [63:0]       mant_reg, mant_next;
    logic [FCNT_W-1:0] frac_reg, frac_next;
    lit_flags_t        lit_reg, lit_next;
    pend_t             pend_reg, pend_next;
    logic [4:0]        err_reg, err_next;
    op_t               op_reg, op_next;
    logic              lit_ret_reg, lit_ret_next;
    logic              neg_reg, neg_next;

    // divider
    logic [DIV_W-1:0]  num_reg, num_next;
    logic [63:0]       den_reg, den_next;
    logic [63:0]       rem_reg, rem_next;
    logic [63:0]       quo_reg, quo_next;
    logic              dovf_reg, dovf_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              div_lit_reg, div_lit_next;

    // multiplier
    logic [63:0]       mx_reg, mx_next, my_reg, my_next;
    logic [63:0]       pp_reg, pp_next;
    logic [1:0]        pos_reg, pos_next;
    logic [2:0]        mcnt_reg, mcnt_next;
    logic [127:0]      acc_reg, acc_next;

    // stack memory
    logic [63:0]       stack_mem [STACK_DEPTH];
    logic [63:0]       rd_a_reg, rd_b_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;

    // push request
    logic              push_en;
    logic [63:0]       push_val;
    logic              push_we;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [63:0]       out_result_reg, out_result_next;
    logic [4:0]        out_flags_reg, out_flags_next;
    logic [3:0]        out_depth_reg, out_depth_next;

    // scratch values
    logic              is_num;
    logic [SP_W-1:0]   sp_m1, sp_m2;
    logic [63:0]       a_val, b_val, sum, m10;
    logic [31:0]       ia, ib, r32, mpa, mpb;
    logic [64:0]       rr;
    logic              ge;
    logic [127:0]      pp_ext, pp_sh, rnd;
    fin_t              fin;
    logic [3:0]        digit;

    assign in_ch.ready          = (state_reg == S_IDLE);
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.scaled_result = out_result_reg;
    assign out_ch.error_flags   = out_flags_reg;
    assign out_ch.final_depth   = out_depth_reg;

    assign is_num = (char_reg inside {[CH_0:CH_9], CH_DOT});
    assign sp_m1  = sp_reg - SP_W'(1);
    assign sp_m2  = sp_reg - SP_W'(2);
    assign a_val  = rd_a_reg;
    assign b_val  = rd_b_reg;

    // stack read and write ports
    always_comb
    begin
        rd_en     = (state_reg == S_OUT_RD) ||
                    ((state_reg == S_OP_RD) && (sp_reg >= SP_W'(2)));
        rd_addr_a = (state_reg == S_OUT_RD) ? '0 : sp_m2[ADDR_W-1:0];
        rd_addr_b = sp_m1[ADDR_W-1:0];
        push_we   = push_en && (sp_reg < SP_W'(STACK_DEPTH));
    end

    always_ff @(posedge clk)
    begin
        if (push_we)
        begin
            stack_mem[sp_reg[ADDR_W-1:0]] <= push_val;
        end
        if (rd_en)
        begin
            rd_a_reg <= stack_mem[rd_addr_a];
            rd_b_reg <= stack_mem[rd_addr_b];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            mant_reg      <= '0;
            frac_reg      <= '0;
            lit_reg       <= '0;
            pend_reg      <= PEND_NONE;
            err_reg       <= '0;
            out_valid_reg <= 1'b0;
            dcnt_reg      <= '0;
            mcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            mant_reg      <= mant_next;
            frac_reg      <= frac_next;
            lit_reg       <= lit_next;
            pend_reg      <= pend_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            dcnt_reg      <= dcnt_next;
            mcnt_reg      <= mcnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            char_reg   <= in_ch.expr_char;
            sample_reg <= in_ch.sample_value;
            last_reg   <= in_ch.last_char;
        end
        op_reg         <= op_next;
        lit_ret_reg    <= lit_ret_next;
        neg_reg        <= neg_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        dovf_reg       <= dovf_next;
        div_lit_reg    <= div_lit_next;
        mx_reg         <= mx_next;
        my_reg         <= my_next;
        pp_reg         <= pp_next;
        pos_reg        <= pos_next;
        acc_reg        <= acc_next;
        out_result_reg <= out_result_next;
        out_flags_reg  <= out_flags_next;
        out_depth_reg  <= out_depth_next;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        sp_next         = sp_reg;
        mant_next       = mant_reg;
        frac_next       = frac_reg;
        lit_next        = lit_reg;
        pend_next       = pend_reg;
        err_next        = err_reg;
        op_next         = op_reg;
        lit_ret_next    = lit_ret_reg;
        neg_next        = neg_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        dovf_next       = dovf_reg;
        dcnt_next       = dcnt_reg;
        div_lit_next    = div_lit_reg;
        mx_next         = mx_reg;
        my_next         = my_reg;
        pp_next         = pp_reg;
        pos_next        = pos_reg;
        mcnt_next       = mcnt_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_result_next = out_result_reg;
        out_flags_next  = out_flags_reg;
        out_depth_next  = out_depth_reg;
        push_en         = 1'b0;
        push_val        = '0;
        sum             = '0;
        m10             = '0;
        ia              = q_to_u32(a_val);
        ib              = q_to_u32(b_val);
        r32             = '0;
        mpa             = '0;
        mpb             = '0;
        rr              = {rem_reg, num_reg[DIV_W-1]};
        ge              = (rr >= {1'b0, den_reg});
        pp_ext          = {64'd0, pp_reg};
        pp_sh           = pp_ext;
        rnd             = '0;
        fin             = '0;
        digit           = 4'(char_reg - CH_0);

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = S_DECODE;
                end
            end

            // a waiting shift character meets its partner
            S_DECODE:
            begin
                pend_next  = PEND_NONE;
                state_next = S_PRE;
                if ((pend_reg == PEND_LT) && (char_reg == CH_LT))
                begin
                    op_next    = OP_SHL;
                    state_next = S_OP_RD;
                end
                else if ((pend_reg == PEND_GT) && (char_reg == CH_GT))
                begin
                    op_next    = OP_SHR;
                    state_next = S_OP_RD;
                end
            end

            // a non-number character closes an open literal first
            S_PRE:
            begin
                if (!is_num && lit_reg.on)
                begin
                    lit_ret_next = 1'b0;
                    state_next   = S_LIT;
                end
                else
                begin
                    state_next = S_CHAR;
                end
            end

            S_CHAR:
            begin
                state_next = S_FIN;
                if (is_num)
                begin
                    lit_next.on = 1'b1;
                    m10 = (mant_reg << 3) + (mant_reg << 1) + 64'(digit);
                    if (!lit_reg.stop)
                    begin
                        if (char_reg == CH_DOT)
                        begin
                            if (lit_reg.dot)
                            begin
                                lit_next.stop = 1'b1;
                            end
                            else
                            begin
                                lit_next.dot = 1'b1;
                            end
                        end
                        else
                        begin
                            lit_next.digit = 1'b1;
                            if (lit_reg.dot)
                            begin
                                if ((frac_reg < FCNT_W'(MAX_FRAC_DIGITS)) &&
                                    (mant_reg < M_LIMIT))
                                begin
                                    mant_next = m10;
                                    frac_next = frac_reg + FCNT_W'(1);
                                end
                            end
                            else if (mant_reg < M_LIMIT)
                            begin
                                mant_next = m10;
                            end
                            else
                            begin
                                mant_next = M_SAT;
                            end
                        end
                    end
                end
                else
                begin
                    case (char_reg)
                        CH_X, CH_XU:
                        begin
                            fin      = q_from_u32(sample_reg);
                            push_en  = 1'b1;
                            push_val = fin.val;
                            if (fin.sat)
                            begin
                                err_next = err_next | E_SAT;
                            end
                        end
                        CH_LT:    pend_next = PEND_LT;
                        CH_GT:    pend_next = PEND_GT;
                        CH_PLUS:  begin op_next = OP_ADD; state_next = S_OP_RD; end
                        CH_MINUS: begin op_next = OP_SUB; state_next = S_OP_RD; end
                        CH_STAR:  begin op_next = OP_MUL; state_next = S_OP_RD; end
                        CH_SLASH: begin op_next = OP_DIV; state_next = S_OP_RD; end
                        CH_PCT:   begin op_next = OP_MOD; state_next = S_OP_RD; end
                        CH_AMP:   begin op_next = OP_AND; state_next = S_OP_RD; end
                        CH_BAR:   begin op_next = OP_OR;  state_next = S_OP_RD; end
                        default:  state_next = S_FIN;
                    endcase
                end
            end

            // end of the character, and of the expression on the last one
            S_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (lit_reg.on)
                begin
                    lit_ret_next = 1'b1;
                    state_next   = S_LIT;
                end
                else
                begin
                    state_next = S_OUT_RD;
                end
            end

            // literal end: special cases or start the scaling divide
            S_LIT:
            begin
                if (!lit_reg.digit || (mant_reg >= M_SAT))
                begin
                    push_en  = 1'b1;
                    push_val = lit_reg.digit ? Q_MAX : 64'd0;
                    err_next = err_next | (lit_reg.digit ? E_SAT : E_LIT);
                    mant_next = '0;
                    frac_next = '0;
                    lit_next  = '0;
                    state_next = lit_ret_reg ? S_OUT_RD : S_CHAR;
                end
                else
                begin
                    num_next     = {mant_reg, FRAC_BITS'(0)} +
                                   DIV_W'(pow_ten(frac_reg) >> 1);
                    den_next     = pow_ten(frac_reg);
                    rem_next     = '0;
                    quo_next     = '0;
                    dovf_next    = 1'b0;
                    dcnt_next    = DCNT_W'(DIV_W);
                    div_lit_next = 1'b1;
                    state_next   = S_DIV;
                end
            end

            // one restoring divide step per cycle
            S_DIV:
            begin
                rem_next  = ge ? 64'(rr - {1'b0, den_reg}) : rr[63:0];
                quo_next  = {quo_reg[62:0], ge};
                dovf_next = dovf_reg | quo_reg[63];
                num_next  = num_reg << 1;
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(1))
                begin
                    state_next = div_lit_reg ? S_LIT_DONE : S_DIV_DONE;
                end
            end

            S_LIT_DONE:
            begin
                fin       = q_finish(quo_reg, 1'b0, dovf_reg);
                push_en   = 1'b1;
                push_val  = fin.val;
                if (fin.sat)
                begin
                    err_next = err_next | E_SAT;
                end
                mant_next  = '0;
                frac_next  = '0;
                lit_next   = '0;
                state_next = lit_ret_reg ? S_OUT_RD : S_CHAR;
            end

            // pop two operands
            S_OP_RD:
            begin
                if (sp_reg < SP_W'(2))
                begin
                    err_next   = err_next | E_UNDER;
                    state_next = S_FIN;
                end
                else
                begin
                    sp_next    = sp_m2;
                    state_next = S_OP_EXEC;
                end
            end

            S_OP_EXEC:
            begin
                state_next = S_FIN;
                case (op_reg)
                    OP_ADD, OP_SUB:
                    begin
                        sum = (op_reg == OP_ADD) ? (a_val + b_val) : (a_val - b_val);
                        push_en  = 1'b1;
                        push_val = sum;
                        if ((((op_reg == OP_ADD) && (a_val[63] == b_val[63])) ||
                             ((op_reg == OP_SUB) && (a_val[63] != b_val[63]))) &&
                            (sum[63] != a_val[63]))
                        begin
                            err_next = err_next | E_SAT;
                            push_val = a_val[63] ? Q_MINMAG : Q_MAX;
                        end
                    end
                    OP_MUL:
                    begin
                        mx_next    = q_mag(a_val);
                        my_next    = q_mag(b_val);
                        neg_next   = a_val[63] ^ b_val[63];
                        acc_next   = '0;
                        mcnt_next  = '0;
                        state_next = S_MUL;
                    end
                    OP_DIV, OP_MOD:
                    begin
                        if (b_val == 64'd0)
                        begin
                            err_next = err_next | E_DIV0;
                            push_en  = 1'b1;
                            push_val = '0;
                        end
                        else
                        begin
                            if (op_reg == OP_DIV)
                            begin
                                num_next = {q_mag(a_val), FRAC_BITS'(0)};
                                neg_next = a_val[63] ^ b_val[63];
                            end
                            else
                            begin
                                num_next = DIV_W'(q_mag(a_val));
                                neg_next = a_val[63];
                            end
                            den_next     = q_mag(b_val);
                            rem_next     = '0;
                            quo_next     = '0;
                            dovf_next    = 1'b0;
                            dcnt_next    = DCNT_W'(DIV_W);
                            div_lit_next = 1'b0;
                            state_next   = S_DIV;
                        end
                    end
                    default:
                    begin
                        case (op_reg)
                            OP_AND:  r32 = ia & ib;
                            OP_OR:   r32 = ia | ib;
                            OP_SHL:  r32 = (ib >= 32'd32) ? 32'd0 : (ia << ib[4:0]);
                            default: r32 = (ib >= 32'd32) ? 32'd0 : (ia >> ib[4:0]);
                        endcase
                        fin      = q_from_u32(r32);
                        push_en  = 1'b1;
                        push_val = fin.val;
                        if (fin.sat)
                        begin
                            err_next = err_next | E_SAT;
                        end
                    end
                endcase
            end

            // partial product into register, accumulated in the cycle after
            S_MUL:
            begin
                case (pos_reg)
                    2'd0:    pp_sh = pp_ext;
                    2'd1:    pp_sh = pp_ext << 32;
                    default: pp_sh = pp_ext << 64;
                endcase
                if (mcnt_reg != 3'd0)
                begin
                    acc_next = acc_reg + pp_sh;
                end
                case (mcnt_reg)
                    3'd0:    begin mpa = mx_reg[31:0];  mpb = my_reg[31:0];  end
                    3'd1:    begin mpa = mx_reg[31:0];  mpb = my_reg[63:32]; end
                    3'd2:    begin mpa = mx_reg[63:32]; mpb = my_reg[31:0];  end
                    default: begin mpa = mx_reg[63:32]; mpb = my_reg[63:32]; end
                endcase
                pp_next   = 64'(mpa) * 64'(mpb);
                pos_next  = (mcnt_reg == 3'd0) ? 2'd0 : ((mcnt_reg == 3'd3) ? 2'd2 : 2'd1);
                mcnt_next = mcnt_reg + 3'd1;
                if (mcnt_reg == 3'd4)
                begin
                    state_next = S_MUL_DONE;
                end
            end

            // round half away from zero, then clamp
            S_MUL_DONE:
            begin
                rnd      = acc_reg + (128'd1 << (FRAC_BITS - 1));
                fin      = q_finish(rnd[FRAC_BITS+63:FRAC_BITS], neg_reg,
                                    |rnd[127:FRAC_BITS+64]);
                push_en  = 1'b1;
                push_val = fin.val;
                if (fin.sat)
                begin
                    err_next = err_next | E_SAT;
                end
                state_next = S_FIN;
            end

            S_DIV_DONE:
            begin
                push_en = 1'b1;
                if (op_reg == OP_DIV)
                begin
                    fin      = q_finish(quo_reg, neg_reg, dovf_reg);
                    push_val = fin.val;
                    if (fin.sat)
                    begin
                        err_next = err_next | E_SAT;
                    end
                end
                else
                begin
                    push_val = neg_reg ? (64'd0 - rem_reg) : rem_reg;
                end
                state_next = S_FIN;
            end

            S_OUT_RD:
            begin
                state_next = S_OUT;
            end

            // load the result and return to the start state
            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_result_next = (sp_reg == '0) ? 64'd0 : rd_a_reg;
                    out_flags_next  = err_reg | ((sp_reg == '0) ? E_UNDER : 5'd0);
                    out_depth_next  = 4'(sp_reg);
                    sp_next         = '0;
                    mant_next       = '0;
                    frac_next       = '0;
                    lit_next        = '0;
                    pend_next       = PEND_NONE;
                    err_next        = '0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // overflow on a dropped push
        if (push_en && !push_we)
        begin
            err_next = err_next | E_OVER;
        end
        if (push_we)
        begin
            sp_next = sp_reg + SP_W'(1);
        end
    end

endmodule

[rtl/rpn_sse_checker.sv]
`timescale 1ns / 1ps

`include "rpn_sensor_scaling_evaluator_core_macros.svh"

module rpn_sse_checker
    import rpn_sse_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_result,
    input logic [4:0]  out_flags,
    input logic [3:0]  out_depth
);

    // a stalled result holds
    `RPN_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_result))

    // an accepted request leaves the block busy in the following cycle
    `RPN_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready)

    // an empty stack reports zero with the underflow flag
    `RPN_ASSERT_IMPLIES(a_empty_result, clk, rst_n, out_valid && (out_depth == 4'd0), (out_result == 64'd0) && out_flags[0])

    // a new result only appears while the block was busy
    `RPN_ASSERT_IMPLIES(a_result_from_busy, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind rpn_sensor_scaling_evaluator_core rpn_sse_checker u_rpn_sse_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_result (out_ch.scaled_result),
    .out_flags  (out_ch.error_flags),
    .out_depth  (out_ch.final_depth)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import rpn_sse_pkg::*;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [63:0] value;
        logic [4:0]  flags;
        logic [3:0]  depth;
    } eval_result_t;

    logic clk;
    logic rst_n;

    rpn_in_if  in_ch();
    rpn_out_if out_ch();

    rpn_sensor_scaling_evaluator_core dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // shadow evaluator state
    logic [63:0] sh_stack [STACK_DEPTH];
    int          sh_sp;
    logic [63:0] sh_mant;
    int          sh_fcnt;
    logic [3:0]  sh_lflags;
    pend_t       sh_pend;
    logic [4:0]  sh_errs;

    eval_result_t pending_results[$];
    int mismatches;
    int chars_sent;
    int results_seen;
    int cycles;
    int src_idle_pct;
    int snk_idle_pct;

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    function automatic logic [63:0] magnitude(logic [63:0] v);
        return v[63] ? 64'd0 - v : v;
    endfunction

    function automatic logic [63:0] saturate(logic [63:0] m, logic neg, logic over);
        logic [63:0] lim;
        lim = neg ? Q_MINMAG : Q_MAX;
        if (over || m > lim)
        begin
            sh_errs |= E_SAT;
            m = lim;
        end
        return neg ? 64'd0 - m : m;
    endfunction

    function automatic logic [31:0] int_part32(logic [63:0] v);
        logic [63:0] ip;
        ip = magnitude(v) >> FRAC_BITS;
        if (v[63])
        begin
            ip = 64'd0 - ip;
        end
        return ip[31:0];
    endfunction

    function automatic logic [63:0] from_int32(logic [31:0] r);
        return saturate({32'd0, r} << FRAC_BITS, 1'b0, 1'b0);
    endfunction

    function automatic void shadow_push(logic [63:0] v);
        if (sh_sp >= STACK_DEPTH)
        begin
            sh_errs |= E_OVER;
        end
        else
        begin
            sh_stack[sh_sp] = v;
            sh_sp++;
        end
    endfunction

    function automatic void shadow_clear();
        sh_sp = 0;
        sh_mant = 64'd0;
        sh_fcnt = 0;
        sh_lflags = 4'd0;
        sh_pend = PEND_NONE;
        sh_errs = 5'd0;
    endfunction

    function automatic logic [63:0] fixed_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        p = p + (128'd1 << (FRAC_BITS - 1));
        return saturate(p[63 + FRAC_BITS:FRAC_BITS], a[63] ^ b[63],
                        p[127:64 + FRAC_BITS] != 0);
    endfunction

    function automatic logic [63:0] fixed_div(logic [63:0] a, logic [63:0] b);
        logic [127:0] num;
        logic [127:0] q;
        if (b == 64'd0)
        begin
            sh_errs |= E_DIV0;
            return 64'd0;
        end
        num = {64'd0, magnitude(a)} << FRAC_BITS;
        q = num / {64'd0, magnitude(b)};
        return saturate(q[63:0], a[63] ^ b[63], q[127:64] != 0);
    endfunction

    function automatic logic [63:0] fixed_mod(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        if (b == 64'd0)
        begin
            sh_errs |= E_DIV0;
            return 64'd0;
        end
        r = magnitude(a) % magnitude(b);
        return a[63] ? 64'd0 - r : r;
    endfunction

    // convert the collected literal and push it
    function automatic void close_literal();
        logic [63:0] v;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] r;
        if (!sh_lflags[0])
        begin
            return;
        end
        if (!sh_lflags[2])
        begin
            sh_errs |= E_LIT;
            v = 64'd0;
        end
        else if (sh_mant >= M_SAT)
        begin
            v = saturate(Q_MAX, 1'b0, 1'b1);
        end
        else
        begin
            p = 64'd1;
            for (int i = 0; i < sh_fcnt && sh_fcnt <= MAX_FRAC_DIGITS; i++)
            begin
                p = p * 10;
            end
            q = sh_mant / p;
            r = sh_mant % p;
            if (q > (Q_MAX >> FRAC_BITS))
            begin
                v = saturate(Q_MAX, 1'b0, 1'b1);
            end
            else
            begin
                v = (q << FRAC_BITS) + (((r << FRAC_BITS) + p / 2) / p);
                v = saturate(v, 1'b0, 1'b0);
            end
        end
        shadow_push(v);
        sh_mant = 64'd0;
        sh_fcnt = 0;
        sh_lflags = 4'd0;
    endfunction

    function automatic void literal_char(logic [7:0] c);
        sh_lflags[0] = 1'b1;
        if (sh_lflags[3])
        begin
            return;
        end
        if (c == CH_DOT)
        begin
            if (sh_lflags[1])
            begin
                sh_lflags[3] = 1'b1;
            end
            else
            begin
                sh_lflags[1] = 1'b1;
            end
            return;
        end
        sh_lflags[2] = 1'b1;
        if (sh_lflags[1])
        begin
            if (sh_fcnt < MAX_FRAC_DIGITS && sh_mant < M_LIMIT)
            begin
                sh_mant = sh_mant * 10 + 64'(c - CH_0);
                sh_fcnt++;
            end
        end
        else if (sh_mant < M_LIMIT)
        begin
            sh_mant = sh_mant * 10 + 64'(c - CH_0);
        end
        else
        begin
            sh_mant = M_SAT;
        end
    endfunction

    function automatic void apply_operator(logic [7:0] op);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        logic [31:0] ia;
        logic [31:0] ib;
        if (sh_sp < 2)
        begin
            sh_errs |= E_UNDER;
            return;
        end
        b = sh_stack[sh_sp - 1];
        a = sh_stack[sh_sp - 2];
        sh_sp -= 2;
        ia = int_part32(a);
        ib = int_part32(b);
        case (op)
            CH_PLUS:
            begin
                r = a + b;
                if (a[63] == b[63] && r[63] != a[63])
                begin
                    sh_errs |= E_SAT;
                    r = a[63] ? Q_MINMAG : Q_MAX;
                end
            end
            CH_MINUS:
            begin
                r = a - b;
                if (a[63] != b[63] && r[63] != a[63])
                begin
                    sh_errs |= E_SAT;
                    r = a[63] ? Q_MINMAG : Q_MAX;
                end
            end
            CH_STAR:  r = fixed_mul(a, b);
            CH_SLASH: r = fixed_div(a, b);
            CH_PCT:   r = fixed_mod(a, b);
            CH_AMP:   r = from_int32(ia & ib);
            CH_BAR:   r = from_int32(ia | ib);
            CH_LT:    r = from_int32(ib >= 32 ? 32'd0 : ia << ib);
            default:  r = from_int32(ib >= 32 ? 32'd0 : ia >> ib);
        endcase
        shadow_push(r);
    endfunction

    // advance the shadow evaluator by one accepted character
    function automatic void evaluate_char(logic [7:0] c, logic [31:0] sample, logic last);
        logic is_num;
        logic done;
        eval_result_t res;
        is_num = (c >= CH_0 && c <= CH_9) || c == CH_DOT;
        done = 1'b0;
        if (sh_pend != PEND_NONE)
        begin
            if ((sh_pend == PEND_LT && c == CH_LT) || (sh_pend == PEND_GT && c == CH_GT))
            begin
                apply_operator(c);
                done = 1'b1;
            end
            sh_pend = PEND_NONE;
        end
        if (!done)
        begin
            if (!is_num)
            begin
                close_literal();
            end
            if (is_num)
            begin
                literal_char(c);
            end
            else if (c == CH_X || c == CH_XU)
            begin
                shadow_push(from_int32(sample));
            end
            else if (c == CH_LT)
            begin
                sh_pend = PEND_LT;
            end
            else if (c == CH_GT)
            begin
                sh_pend = PEND_GT;
            end
            else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
                     c == CH_PCT || c == CH_AMP || c == CH_BAR)
            begin
                apply_operator(c);
            end
        end
        if (!last)
        begin
            return;
        end
        close_literal();
        if (sh_sp == 0)
        begin
            sh_errs |= E_UNDER;
            res.value = 64'd0;
        end
        else
        begin
            res.value = sh_stack[0];
        end
        res.flags = sh_errs;
        res.depth = sh_sp[3:0];
        pending_results.push_back(res);
        shadow_clear();
    endfunction

    // receiver ready with random back pressure
    always @(negedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // compare each delivered result with the oldest prediction
    always @(posedge clk)
    begin
        eval_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected result %h", out_ch.scaled_result));
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.scaled_result !== want.value)
                begin
                    report($sformatf("scaled_result %h, want %h",
                                     out_ch.scaled_result, want.value));
                end
                if (out_ch.error_flags !== want.flags)
                begin
                    report($sformatf("error_flags %b, want %b",
                                     out_ch.error_flags, want.flags));
                end
                if (out_ch.final_depth !== want.depth)
                begin
                    report($sformatf("final_depth %0d, want %0d",
                                     out_ch.final_depth, want.depth));
                end
            end
        end
    end

    // one character request, held until accepted
    task automatic send_char(input logic [7:0] c, input logic [31:0] sample, input logic last);
        if ($urandom_range(99) < src_idle_pct)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.expr_char <= c;
        in_ch.sample_value <= sample;
        in_ch.last_char <= last;
        do
        begin
            @(posedge clk);
        end
        while (!(in_ch.valid && in_ch.ready));
        evaluate_char(c, sample, last);
        chars_sent++;
    endtask

    task automatic send_expr(input logic [7:0] chars[$], input logic [31:0] sample);
        for (int i = 0; i < chars.size(); i++)
        begin
            send_char(chars[i], sample, i == chars.size() - 1);
        end
    endtask

    task automatic send_text(input string s, input logic [31:0] sample);
        logic [7:0] chars[$];
        for (int i = 0; i < s.len(); i++)
        begin
            chars.push_back(s[i]);
        end
        send_expr(chars, sample);
    endtask

    // drop the request and wait for every expected result
    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // directed: extremes, every operator and the corner cases
    task automatic test_directed();
        send_text("x 2 *", 32'hFFFF_FFFF);
        send_text("1.5 2.25 + 0.75 -", 32'd0);
        send_text("0 5 / 5 0 /", 32'd0);
        send_text("7 0 % x 3 %", 32'd100);
        send_text("0 5 - 3 % 7 /", 32'd0);
        send_text("+", 32'd0);
        send_text(" ", 32'd0);
        send_text("xxxxxxxxxxx+", 32'h8000_0001);
        send_text(". 1..5 +", 32'd0);
        send_text("3 1 << 256 4 >> |", 32'd0);
        send_text("5 < 3 > &", 32'd0);
        send_text("99999999999999999999", 32'd0);
        send_text("549755813888 0.1234567891234", 32'd0);
        send_text("x x * X *", 32'hFFFF_FFFF);
        send_text("1 40 << 2 33 >> X 1 -", 32'h5555_AAAA);
        send_text("0 1 - 9 *", 32'd0);
        send_text(string'({8'hFF, "7", 8'h80, "3.", 8'h01, "+"}), 32'd0);
    endtask

    // random postfix expression, mostly well formed
    task automatic send_random_expr(input bit broken);
        logic [7:0] chars[$];
        int depth;
        int ntok;
        int ndig;
        logic [7:0] ops[9];
        ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_AMP, CH_BAR, CH_LT, CH_GT};
        depth = 0;
        ntok = $urandom_range(1, 8);
        for (int t = 0; t < ntok; t++)
        begin
            if (t != 0 || $urandom_range(3) == 0)
            begin
                chars.push_back(CH_SPACE);
            end
            if ($urandom_range(9) == 0)
            begin
                chars.push_back(8'($urandom_range(255)));
            end
            else if ((depth >= 2 || broken) && $urandom_range(1) == 0)
            begin
                chars.push_back(ops[$urandom_range(8)]);
                if (chars[$] == CH_LT || chars[$] == CH_GT)
                begin
                    if ($urandom_range(7) != 0)
                    begin
                        chars.push_back(chars[$]);
                    end
                end
                depth = depth > 0 ? depth - 1 : 0;
            end
            else if ($urandom_range(2) == 0)
            begin
                chars.push_back($urandom_range(1) ? CH_X : CH_XU);
                depth++;
            end
            else
            begin
                ndig = ($urandom_range(15) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 3);
                for (int d = 0; d < ndig; d++)
                begin
                    chars.push_back(8'(CH_0 + $urandom_range(9)));
                end
                if ($urandom_range(2) == 0)
                begin
                    chars.push_back(CH_DOT);
                    ndig = ($urandom_range(7) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 3);
                    for (int d = 0; d < ndig; d++)
                    begin
                        chars.push_back(8'(CH_0 + $urandom_range(9)));
                    end
                    if ($urandom_range(15) == 0)
                    begin
                        chars.push_back(CH_DOT);
                    end
                end
                depth++;
            end
        end
        send_expr(chars, $urandom());
    endtask

    task automatic test_random(input int nchars, input int src_pct, input int snk_pct,
                               input bit hold_off);
        int stop_at;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        stop_at = chars_sent + nchars;
        while (chars_sent < stop_at)
        begin
            send_random_expr($urandom_range(9) == 0);
            if (hold_off && $urandom_range(7) == 0)
            begin
                wait_drained();
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.expr_char = 8'd0;
        in_ch.sample_value = 32'd0;
        in_ch.last_char = 1'b0;
        out_ch.ready = 1'b0;
        src_idle_pct = 28;
        snk_idle_pct = 58;
        shadow_clear();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(370, 28, 58, 1'b1);
        test_random(370, 58, 28, 1'b0);
        test_random(370, 0, 0, 1'b0);

        @(negedge clk);
        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d characters and checked %0d results", chars_sent, results_seen);
        $display("covered literals, sample pushes, all operators and error flags");
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
